// ===== rtl/steqr_pkg.sv =====
package steqr_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned IDX_W       = 11;
  localparam int unsigned REQ_W       = 2;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned OUT_DATA_W  = 24;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Flip the sign bit so an unsigned compare gives signed order.
  localparam logic [VALUE_W-1:0] SIGN_BIAS = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [IDX_W-1:0]   IDX_NONE  = {IDX_W{1'b1}};

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_UNUSED = 2'd3
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_LOAD_DONE = 2'd0,
    STAT_FOUND     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CHECK,
    S_RESULT
  } state_e;

  typedef struct packed {
    req_e                req;
    logic [VALUE_W-1:0]  key;
  } cmd_t;

endpackage

// ===== rtl/steqr_ram.sv =====
module steqr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/steqr_front.sv =====
module steqr_front
  import steqr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [REQ_W-1:0]   in_req_i,
  input  logic [VALUE_W-1:0] in_value_i,
  output logic               push_o,
  output cmd_t               cmd_o,
  input  logic               q_ready_i
);

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic take;

  assign in_ready_o = !valid_q || q_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign push_o     = valid_q && q_ready_i;
  assign cmd_o      = cmd_q;

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (push_o) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d   = 1'b1;
      cmd_d.req = req_e'(in_req_i);
      // store biased so the back end compares unsigned
      cmd_d.key = in_value_i ^ SIGN_BIAS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule

// ===== rtl/steqr_queue.sv =====
module steqr_queue
  import steqr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic ready_o,
  output logic valid_o,
  output cmd_t cmd_o,
  input  logic pop_i
);

  cmd_t              entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign ready_o = cnt_q != QCNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign cmd_o   = entries_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== rtl/steqr_back.sv =====
module steqr_back
  import steqr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  cmd_t                  q_cmd_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [STATUS_W-1:0]   out_status_o,
  output logic [IDX_W-1:0]      out_first_o,
  output logic [IDX_W-1:0]      out_last_o
);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, lb_q, lb_d;
  logic               upper_q, upper_d;
  logic [VALUE_W-1:0] key_q, key_d;
  status_e            res_status_q, res_status_d;
  logic [IDX_W-1:0]   res_first_q, res_first_d, res_last_q, res_last_d;
  logic               out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q;
  logic [IDX_W-1:0]   out_first_q, out_last_q;
  logic               out_load;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  logic               go_right;
  logic [CNT_W-1:0]   step_lo, step_hi, step_mid, start_mid, ub_last;

  steqr_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (q_cmd_i.key),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // one halving step per cycle; the probe read for the next step issues at once
  assign go_right  = upper_q ? (ram_rdata <= key_q) : (ram_rdata < key_q);
  assign step_lo   = go_right ? mid_q + 1'b1 : lo_q;
  assign step_hi   = go_right ? hi_q : mid_q;
  assign step_mid  = step_lo + ((step_hi - step_lo) >> 1);
  assign start_mid = count_q >> 1;
  assign ub_last   = (step_lo > lb_q) ? step_lo - 1'b1 : lb_q;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    lb_d         = lb_q;
    upper_d      = upper_q;
    key_d        = key_q;
    res_status_d = res_status_q;
    res_first_d  = res_first_q;
    res_last_d   = res_last_q;
    q_pop_o      = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = count_q[ADDR_W-1:0];
    ram_raddr    = mid_q[ADDR_W-1:0];
    out_load     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o      = 1'b1;
          key_d        = q_cmd_i.key;
          res_status_d = STAT_LOAD_DONE;
          res_first_d  = IDX_NONE;
          res_last_d   = IDX_NONE;
          state_d      = S_RESULT;
          unique case (q_cmd_i.req)
            REQ_CLEAR: begin
              count_d = '0;
            end
            REQ_APPEND: begin
              if (count_q == CNT_W'(TABLE_DEPTH)) begin
                res_status_d = STAT_FULL;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            REQ_SEARCH: begin
              if (count_q == '0) begin
                res_status_d = STAT_NOT_FOUND;
              end else begin
                lo_d      = '0;
                hi_d      = count_q;
                mid_d     = start_mid;
                ram_re    = 1'b1;
                ram_raddr = start_mid[ADDR_W-1:0];
                upper_d   = 1'b0;
                state_d   = S_PROBE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_PROBE: begin
        lo_d = step_lo;
        hi_d = step_hi;
        if (step_lo < step_hi) begin
          mid_d     = step_mid;
          ram_re    = 1'b1;
          ram_raddr = step_mid[ADDR_W-1:0];
        end else if (!upper_q) begin
          lb_d = step_lo;
          if (step_lo < count_q) begin
            ram_re    = 1'b1;
            ram_raddr = step_lo[ADDR_W-1:0];
            state_d   = S_CHECK;
          end else begin
            res_status_d = STAT_NOT_FOUND;
            state_d      = S_RESULT;
          end
        end else begin
          res_status_d = STAT_FOUND;
          res_first_d  = IDX_W'(lb_q);
          res_last_d   = IDX_W'(ub_last);
          state_d      = S_RESULT;
        end
      end

      S_CHECK: begin
        if (ram_rdata == key_q) begin
          lo_d      = '0;
          hi_d      = count_q;
          mid_d     = start_mid;
          ram_re    = 1'b1;
          ram_raddr = start_mid[ADDR_W-1:0];
          upper_d   = 1'b1;
          state_d   = S_PROBE;
        end else begin
          res_status_d = STAT_NOT_FOUND;
          state_d      = S_RESULT;
        end
      end

      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    lb_q         <= lb_d;
    upper_q      <= upper_d;
    key_q        <= key_d;
    res_status_q <= res_status_d;
    res_first_q  <= res_first_d;
    res_last_q   <= res_last_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_first_q  <= res_first_q;
      out_last_q   <= res_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_first_o  = out_first_q;
  assign out_last_o   = out_last_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_probe_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) |-> (lo_q <= mid_q && mid_q < hi_q && hi_q <= count_q))
    else $error("probe index outside search window");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_IDLE && count_q < CNT_W'(TABLE_DEPTH)))
    else $error("table write outside an accepted append");

  a_probe_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE || state_q == S_CHECK) |-> $past(ram_re))
    else $error("compare without a read in flight");
`endif

endmodule

// ===== rtl/sorted_table_equal_range_search.sv =====
// Sorted table with equal-range search. Software loads signed 32-bit values in
// nondecreasing order by sending a clear (tuser 0) and then appends (tuser 1);
// a search (tuser 2) returns the first and last index holding the value, found
// with a lower-bound and an upper-bound binary search over a simple dual-port
// table RAM. Every request gives exactly one result transfer: status 0 for a
// clear, an append or the unused code 3; status 3 when an append hits a full
// table (the value is dropped); status 1 with both indices on a hit; status 2
// with both indices at -1 on a miss or an empty table. The table is never
// swept after reset: only entries below the fill count are read. Load order is
// not checked; an unsorted table gives the indices the two searches land on.
// A request passes an input register and a two-entry queue before the
// search engine, so a new transfer is taken while a search runs or a result
// waits, until the queue is full. Clear and append then pass the idle and
// result states and the output register. A search runs the lower-bound probes,
// a check read and, on a hit, the upper-bound probes, one RAM read per halving
// step, and one request is worked on at a time.
module sorted_table_equal_range_search
  import steqr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [VALUE_W-1:0]    s_axis_tdata_i,  // [31:0] item_value
  input  logic [REQ_W-1:0]      s_axis_tuser_i,  // [1:0] req_type
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,  // [10:0] first_index, [21:11] last_index
  output logic [STATUS_W-1:0]   m_axis_tuser_o   // [1:0] status
);

  logic             push;
  logic             q_ready;
  cmd_t             front_cmd;
  logic             q_valid;
  cmd_t             q_cmd;
  logic             q_pop;
  logic [IDX_W-1:0] first_idx, last_idx;

  // Decode the request kind and bias the value for unsigned ordering.
  steqr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_req_i   (s_axis_tuser_i),
    .in_value_i (s_axis_tdata_i),
    .push_o     (push),
    .cmd_o      (front_cmd),
    .q_ready_i  (q_ready)
  );

  // Hold decoded requests so the input side keeps taking transfers during a search.
  steqr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .cmd_o   (q_cmd),
    .pop_i   (q_pop)
  );

  // Own the table and fill count, run both searches, register the result.
  steqr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_cmd_i      (q_cmd),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (m_axis_tuser_o),
    .out_first_o  (first_idx),
    .out_last_o   (last_idx)
  );

  // Pack indices from the low bit up, zero-fill to whole bytes.
  assign m_axis_tdata_o = OUT_DATA_W'({last_idx, first_idx});

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import steqr_pkg::*;

  // One predicted response: what the block must answer for one request.
  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] last;
  } range_answer_t;

  // One row of the directed table. Rows with pinned set carry a hand-typed answer.
  typedef struct packed {
    req_e               req;
    logic [VALUE_W-1:0] value;
    logic               pinned;
    status_e            status;
    logic [IDX_W-1:0]   first;
    logic [IDX_W-1:0]   last;
  } directed_row_t;

  localparam int unsigned NUM_DIRECTED = 25;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [VALUE_W-1:0]    s_axis_tdata_i;   // [31:0] item_value
  logic [REQ_W-1:0]      s_axis_tuser_i;   // [1:0] req_type
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;   // [10:0] first_index, [21:11] last_index
  logic [STATUS_W-1:0]   m_axis_tuser_o;   // [1:0] status

  // Shadow copy of the table and its fill count, kept in step with accepted requests.
  logic signed [VALUE_W-1:0] shadow_entries [TABLE_DEPTH];
  int unsigned               fill_count;

  range_answer_t pending_ranges [$];
  int            error_count;
  int            items_sent;
  int            burst_left;

  // Receiver stall pattern state.
  int unsigned   stall_mode;
  int unsigned   stall_timer;
  int unsigned   ready_phase;

  directed_row_t directed_rows [NUM_DIRECTED];

  sorted_table_equal_range_search i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #4 clk_i = ~clk_i;

  // Binary search over the valid entries: first index not below the key
  // (lower bound) or first index above the key (upper bound).
  function automatic int unsigned bound_position(logic signed [VALUE_W-1:0] key,
                                                 logic upper);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    logic        go_right;
    lo = 0;
    hi = fill_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      go_right = upper ? (shadow_entries[mid] <= key) : (shadow_entries[mid] < key);
      if (go_right) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    return lo;
  endfunction

  // Advance the shadow state by one request and return the answer it must produce.
  function automatic range_answer_t equal_range_outcome(req_e req, logic [VALUE_W-1:0] value);
    range_answer_t answer;
    int unsigned   lower_idx;
    int unsigned   upper_idx;
    answer.status = STAT_LOAD_DONE;
    answer.first  = IDX_NONE;
    answer.last   = IDX_NONE;
    case (req)
      REQ_CLEAR: begin
        fill_count = 0;
      end
      REQ_APPEND: begin
        if (fill_count >= TABLE_DEPTH) begin
          answer.status = STAT_FULL;
        end else begin
          shadow_entries[fill_count] = value;
          fill_count++;
        end
      end
      REQ_SEARCH: begin
        lower_idx = bound_position(value, 1'b0);
        if (lower_idx < fill_count && shadow_entries[lower_idx] == value) begin
          upper_idx     = bound_position(value, 1'b1);
          answer.status = STAT_FOUND;
          answer.first  = IDX_W'(lower_idx);
          // Never let last fall below first, even on a badly ordered table.
          answer.last   = (upper_idx > lower_idx) ? IDX_W'(upper_idx - 1) : IDX_W'(lower_idx);
        end else begin
          answer.status = STAT_NOT_FOUND;
        end
      end
      default: ;
    endcase
    return answer;
  endfunction

  // Drive one request and hold it until the transfer completes. Idle between bursts
  // of random length; a zero-length gap keeps tvalid high into the next request.
  task automatic send_request(input req_e req, input logic [VALUE_W-1:0] value,
                              input logic pinned, input range_answer_t pinned_answer);
    range_answer_t answer;
    int unsigned   idle_cycles;
    if (burst_left == 0) begin
      idle_cycles = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 29) == 0) begin
        idle_cycles = $urandom_range(20, 40);
      end
      if (idle_cycles > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (idle_cycles) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 96) : $urandom_range(1, 12);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    s_axis_tuser_i  <= req;
    do @(posedge clk_i); while (!s_axis_tready_o);
    answer = equal_range_outcome(req, value);
    pending_ranges.insert(pending_ranges.size(), pinned ? pinned_answer : answer);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_checked(input req_e req, input logic [VALUE_W-1:0] value);
    send_request(req, value, 1'b0, '0);
  endtask

  // Load a sorted run of values, then search it. A few appends break the order
  // and a few unused codes are mixed in as noise.
  task automatic load_and_search(input int unsigned entries, input int unsigned searches,
                                 input logic with_clear);
    int          sorted_values [$];
    int          base;
    int unsigned spread;
    int unsigned pick;
    int unsigned idx;
    logic [VALUE_W-1:0] target;
    base   = $urandom;
    // Narrow spread packs many duplicates; zero spread means a wide random mix.
    spread = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, entries / 2 + 2);
    repeat (entries) begin
      if (spread == 0) begin
        sorted_values.insert(sorted_values.size(), $urandom);
      end else begin
        sorted_values.insert(sorted_values.size(), base + $urandom_range(0, spread));
      end
    end
    if (entries > 0 && $urandom_range(0, 7) == 0) begin
      sorted_values.insert(sorted_values.size(), 32'sh8000_0000);
      sorted_values.insert(sorted_values.size(), 32'sh7FFF_FFFF);
    end
    sorted_values.sort();
    if (with_clear) begin
      send_checked(REQ_CLEAR, $urandom);
    end
    foreach (sorted_values[i]) begin
      if ($urandom_range(0, 49) == 0) begin
        send_checked(REQ_APPEND, $urandom);
      end else begin
        send_checked(REQ_APPEND, sorted_values[i]);
      end
      if ($urandom_range(0, 39) == 0) begin
        send_checked(REQ_UNUSED, $urandom);
      end
    end
    repeat (searches) begin
      pick = $urandom_range(0, 9);
      if (sorted_values.size() > 0 && pick < 6) begin
        idx    = $urandom_range(0, sorted_values.size() - 1);
        target = sorted_values[idx];
      end else if (sorted_values.size() > 0 && pick < 8) begin
        // Probe just beside a stored value for near misses.
        idx    = $urandom_range(0, sorted_values.size() - 1);
        target = ($urandom_range(0, 1) != 0) ? sorted_values[idx] + 1 : sorted_values[idx] - 1;
      end else begin
        target = $urandom;
      end
      send_checked(REQ_SEARCH, target);
      if ($urandom_range(0, 29) == 0) begin
        send_checked(req_e'($urandom_range(0, 3)), $urandom);
      end
    end
  endtask

  // Receiver: switch between stall patterns at random intervals, including
  // stretches with no stall at all.
  always @(posedge clk_i) begin
    if (stall_timer == 0) begin
      stall_mode  <= $urandom_range(0, 3);
      stall_timer <= $urandom_range(50, 300);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    ready_phase <= ready_phase + 1;
    case (stall_mode)
      0:       m_axis_tready_i <= 1'b1;
      1:       m_axis_tready_i <= ($urandom_range(0, 1) != 0);
      2:       m_axis_tready_i <= ready_phase[3];
      default: m_axis_tready_i <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // Compare every result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    range_answer_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_ranges.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d tdata %h",
                 $time, m_axis_tuser_o, m_axis_tdata_o);
        error_count++;
      end else begin
        want = pending_ranges.pop_front();
        if (m_axis_tuser_o != want.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, want.status, m_axis_tuser_o);
          error_count++;
        end
        if (m_axis_tdata_o[IDX_W-1:0] != want.first) begin
          $display("%0t: first_index expected %h actual %h",
                   $time, want.first, m_axis_tdata_o[IDX_W-1:0]);
          error_count++;
        end
        if (m_axis_tdata_o[2*IDX_W-1:IDX_W] != want.last) begin
          $display("%0t: last_index expected %h actual %h",
                   $time, want.last, m_axis_tdata_o[2*IDX_W-1:IDX_W]);
          error_count++;
        end
        if (m_axis_tdata_o[OUT_DATA_W-1:2*IDX_W] != '0) begin
          $display("%0t: tdata pad expected 0 actual %h",
                   $time, m_axis_tdata_o[OUT_DATA_W-1:2*IDX_W]);
          error_count++;
        end
      end
    end
  end

  initial begin
    directed_rows = '{
      // Empty table right after reset.
      '{REQ_SEARCH, 32'h0000_0000, 1'b1, STAT_NOT_FOUND, IDX_NONE, IDX_NONE},
      '{REQ_SEARCH, 32'h7FFF_FFFF, 1'b1, STAT_NOT_FOUND, IDX_NONE, IDX_NONE},
      // Load extremes with duplicates.
      '{REQ_APPEND, 32'h8000_0000, 1'b1, STAT_LOAD_DONE, IDX_NONE, IDX_NONE},
      '{REQ_APPEND, 32'h8000_0000, 1'b1, STAT_LOAD_DONE, IDX_NONE, IDX_NONE},
      '{REQ_APPEND, 32'hFFFF_FFFF, 1'b1, STAT_LOAD_DONE, IDX_NONE, IDX_NONE},
      '{REQ_APPEND, 32'h0000_0000, 1'b1, STAT_LOAD_DONE, IDX_NONE, IDX_NONE},
      '{REQ_APPEND, 32'h0000_0000, 1'b0, STAT_LOAD_DONE, IDX_NONE, IDX_NONE},
      '{REQ_APPEND, 32'h0000_0000, 1'b0, STAT_LOAD_DONE, IDX_NONE, IDX_NONE},
      '{REQ_APPEND, 32'h7FFF_FFFF, 1'b1, STAT_LOAD_DONE, IDX_NONE, IDX_NONE},
      // Hits at both ends and on a run of duplicates.
      '{REQ_SEARCH, 32'h8000_0000, 1'b1, STAT_FOUND, 11'd0, 11'd1},
      '{REQ_SEARCH, 32'hFFFF_FFFF, 1'b1, STAT_FOUND, 11'd2, 11'd2},
      '{REQ_SEARCH, 32'h0000_0000, 1'b1, STAT_FOUND, 11'd3, 11'd5},
      '{REQ_SEARCH, 32'h7FFF_FFFF, 1'b1, STAT_FOUND, 11'd6, 11'd6},
      // Absent values between stored entries.
      '{REQ_SEARCH, 32'h0000_0001, 1'b1, STAT_NOT_FOUND, IDX_NONE, IDX_NONE},
      '{REQ_SEARCH, 32'h8000_0001, 1'b1, STAT_NOT_FOUND, IDX_NONE, IDX_NONE},
      // Unused code answers like a load and must leave the table alone.
      '{REQ_UNUSED, 32'hFFFF_FFFF, 1'b1, STAT_LOAD_DONE, IDX_NONE, IDX_NONE},
      '{REQ_SEARCH, 32'h0000_0000, 1'b0, STAT_LOAD_DONE, IDX_NONE, IDX_NONE},
      // Clear keeps the old contents in memory but they must not match.
      '{REQ_CLEAR,  32'hA5A5_5A5A, 1'b1, STAT_LOAD_DONE, IDX_NONE, IDX_NONE},
      '{REQ_SEARCH, 32'h0000_0000, 1'b1, STAT_NOT_FOUND, IDX_NONE, IDX_NONE},
      // Out-of-order load: answers follow where the two searches land.
      '{REQ_APPEND, 32'h0000_0005, 1'b0, STAT_LOAD_DONE, IDX_NONE, IDX_NONE},
      '{REQ_APPEND, 32'h0000_0001, 1'b0, STAT_LOAD_DONE, IDX_NONE, IDX_NONE},
      '{REQ_APPEND, 32'h0000_0003, 1'b0, STAT_LOAD_DONE, IDX_NONE, IDX_NONE},
      '{REQ_SEARCH, 32'h0000_0001, 1'b0, STAT_LOAD_DONE, IDX_NONE, IDX_NONE},
      '{REQ_SEARCH, 32'h0000_0003, 1'b0, STAT_LOAD_DONE, IDX_NONE, IDX_NONE},
      '{REQ_SEARCH, 32'h0000_0005, 1'b0, STAT_LOAD_DONE, IDX_NONE, IDX_NONE}
    };
    error_count     = 0;
    items_sent      = 0;
    burst_left      = 0;
    fill_count      = 0;
    stall_mode      = 0;
    stall_timer     = 0;
    ready_phase     = 0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = REQ_CLEAR;
    m_axis_tready_i = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].value, directed_rows[i].pinned,
                   '{directed_rows[i].status, directed_rows[i].first, directed_rows[i].last});
    end

    while (items_sent < 500) begin
      load_and_search(($urandom_range(0, 9) == 0) ? $urandom_range(25, 200)
                                                  : $urandom_range(0, 24),
                      $urandom_range(1, 16), $urandom_range(0, 9) != 0);
    end

    // Hold off the sender until the block has drained every result.
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_ranges.size() != 0);

    // Fill the table to the top; the last appends hit a full table and are dropped.
    load_and_search(TABLE_DEPTH + 2, 48, 1'b1);

    while (items_sent < 1600) begin
      load_and_search(($urandom_range(0, 9) == 0) ? $urandom_range(25, 200)
                                                  : $urandom_range(0, 24),
                      $urandom_range(1, 16), $urandom_range(0, 9) != 0);
    end

    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_ranges.size() != 0);
    // Watch a while longer for stray result transfers.
    repeat (60) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/steqr_pkg.sv
rtl/steqr_ram.sv
rtl/steqr_front.sv
rtl/steqr_queue.sv
rtl/steqr_back.sv
rtl/sorted_table_equal_range_search.sv
tb/tb_top.sv
